// ----- design/bps_pkg.sv -----
// shared types, register codes and saturation helper for the brownian step core
// no dependencies; every other design file takes names from here by scope
package bps_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned FracW  = 28;
    localparam int unsigned SqrtSt = 32;
    localparam int unsigned QuoW   = 31;

    typedef logic [WordW-1:0] t_word;
    typedef logic [2:0][WordW-1:0] t_vec3;

    // register map index
    typedef enum logic {
        REG_TRANS_BASE = 1'b0,
        REG_ROT_BASE   = 1'b1
    } t_reg_idx;

    typedef struct packed {
        t_word trans_base;
        t_word rot_base;
    } t_cfg;

    // data travelling alongside the arithmetic; dir holds the director, unnormalised until the divider
    typedef struct packed {
        t_vec3 disp;
        t_vec3 turn;
        t_vec3 dir;
    } t_carry;

    typedef struct packed {
        logic [59:0]     rem;
        logic [QuoW-1:0] q;
        logic            ovf;
        logic            neg;
    } t_div_lane;

    typedef struct packed {
        t_div_lane [2:0] lane;
        t_word           len;
        logic            degen;
        t_vec3           disp;
        t_vec3           turn;
    } t_div_st;

    // clamp to the signed 32-bit range
    function automatic t_word f_sat32(input logic signed [37:0] v);
        t_word r;
        if (v > 38'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- design/bps_in_if.sv -----
// input channel of the brownian step core: one particle word per handshake
// depends on bps_pkg for the word type
interface bps_in_if;
    logic          valid;
    logic          ready;
    bps_pkg::t_word force_x;
    bps_pkg::t_word force_y;
    bps_pkg::t_word force_z;
    bps_pkg::t_word torque_x;
    bps_pkg::t_word torque_y;
    bps_pkg::t_word torque_z;
    bps_pkg::t_word dir_in_x;
    bps_pkg::t_word dir_in_y;
    bps_pkg::t_word dir_in_z;
    bps_pkg::t_word trans_scale;
    bps_pkg::t_word rot_scale;

    modport source (output valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                    dir_in_x, dir_in_y, dir_in_z, trans_scale, rot_scale, input ready);
    modport sink   (input valid, force_x, force_y, force_z, torque_x, torque_y, torque_z,
                    dir_in_x, dir_in_y, dir_in_z, trans_scale, rot_scale, output ready);
endinterface

// ----- design/bps_out_if.sv -----
// output channel of the brownian step core: one result word per handshake
// depends on bps_pkg for the word type
interface bps_out_if;
    logic          valid;
    logic          ready;
    bps_pkg::t_word disp_x;
    bps_pkg::t_word disp_y;
    bps_pkg::t_word disp_z;
    bps_pkg::t_word turn_x;
    bps_pkg::t_word turn_y;
    bps_pkg::t_word turn_z;
    bps_pkg::t_word dir_out_x;
    bps_pkg::t_word dir_out_y;
    bps_pkg::t_word dir_out_z;
    logic          degenerate;

    modport source (output valid, disp_x, disp_y, disp_z, turn_x, turn_y, turn_z,
                    dir_out_x, dir_out_y, dir_out_z, degenerate, input ready);
    modport sink   (input valid, disp_x, disp_y, disp_z, turn_x, turn_y, turn_z,
                    dir_out_x, dir_out_y, dir_out_z, degenerate, output ready);
endinterface

// ----- design/bps_regs.sv -----
// apb-style register block holding the two mobility bases
// depends on bps_pkg for the register map and config struct
module bps_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output bps_pkg::t_cfg o_cfg
);
    bps_pkg::t_cfg    r_cfg;
    bps_pkg::t_reg_idx w_idx;

    assign w_idx  = bps_pkg::t_reg_idx'(paddr[2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                bps_pkg::REG_TRANS_BASE: r_cfg.trans_base <= pwdata;
                bps_pkg::REG_ROT_BASE:   r_cfg.rot_base   <= pwdata;
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb begin
        case (w_idx)
            bps_pkg::REG_TRANS_BASE: prdata = r_cfg.trans_base;
            bps_pkg::REG_ROT_BASE:   prdata = r_cfg.rot_base;
            default:                 prdata = '0;
        endcase
    end
endmodule

// ----- design/bps_front.sv -----
// seven-stage front end: mobilities, displacement, turn, cross product, new director
// and its squared length; depends on bps_pkg
module bps_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  bps_pkg::t_vec3  i_force,
    input  bps_pkg::t_vec3  i_torque,
    input  bps_pkg::t_vec3  i_dir,
    input  bps_pkg::t_word  i_trans_scale,
    input  bps_pkg::t_word  i_rot_scale,
    input  bps_pkg::t_cfg   i_cfg,
    output logic            o_vld,
    output bps_pkg::t_carry o_carry,
    output logic [63:0]     o_sum
);
    logic [7:1] r_vld;

    // stage 1
    logic [63:0]    r1_pm_t, r1_pm_r;
    bps_pkg::t_vec3 r1_f, r1_t, r1_d;
    // stage 2
    logic signed [64:0] r2_pf [3];
    logic signed [64:0] r2_pt [3];
    bps_pkg::t_vec3     r2_d;
    // stage 3
    bps_pkg::t_vec3 r3_disp, r3_turn, r3_d;
    // stage 4
    logic signed [63:0] r4_a [3];
    logic signed [63:0] r4_b [3];
    bps_pkg::t_vec3     r4_disp, r4_turn, r4_d;
    // stage 5
    bps_pkg::t_carry r5_c;
    // stage 6
    logic [63:0]     r6_sq [3];
    bps_pkg::t_carry r6_c;
    // stage 7
    logic [63:0]     r7_sum;
    bps_pkg::t_carry r7_c;

    logic [31:0] w_mt, w_mr;
    logic [35:0] w_sh_t, w_sh_r;

    // mobility saturation to unsigned 32 bits
    assign w_sh_t = r1_pm_t[63:28];
    assign w_sh_r = r1_pm_r[63:28];
    assign w_mt   = (|w_sh_t[35:32]) ? 32'hFFFF_FFFF : w_sh_t[31:0];
    assign w_mr   = (|w_sh_r[35:32]) ? 32'hFFFF_FFFF : w_sh_r[31:0];

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[6:1], i_vld};
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        logic signed [64:0] diff;
        logic signed [37:0] acc;
        logic        [31:0] mag;
        if (i_en) begin
            r1_pm_t <= 64'(i_trans_scale) * 64'(i_cfg.trans_base);
            r1_pm_r <= 64'(i_rot_scale) * 64'(i_cfg.rot_base);
            r1_f    <= i_force;
            r1_t    <= i_torque;
            r1_d    <= i_dir;

            for (int i = 0; i < 3; i++) begin
                r2_pf[i] <= $signed({1'b0, w_mt}) * $signed(r1_f[i]);
                r2_pt[i] <= $signed({1'b0, w_mr}) * $signed(r1_t[i]);
            end
            r2_d <= r1_d;

            for (int i = 0; i < 3; i++) begin
                r3_disp[i] <= bps_pkg::f_sat32($signed({r2_pf[i][64], r2_pf[i][64:28]}));
                r3_turn[i] <= bps_pkg::f_sat32($signed({r2_pt[i][64], r2_pt[i][64:28]}));
            end
            r3_d <= r2_d;

            // cross product terms of turn x dir
            r4_a[0] <= $signed(r3_turn[1]) * $signed(r3_d[2]);
            r4_b[0] <= $signed(r3_turn[2]) * $signed(r3_d[1]);
            r4_a[1] <= $signed(r3_turn[2]) * $signed(r3_d[0]);
            r4_b[1] <= $signed(r3_turn[0]) * $signed(r3_d[2]);
            r4_a[2] <= $signed(r3_turn[0]) * $signed(r3_d[1]);
            r4_b[2] <= $signed(r3_turn[1]) * $signed(r3_d[0]);
            r4_disp <= r3_disp;
            r4_turn <= r3_turn;
            r4_d    <= r3_d;

            // director plus cross, floored and clamped
            for (int i = 0; i < 3; i++) begin
                diff = {r4_a[i][63], r4_a[i]} - {r4_b[i][63], r4_b[i]};
                acc  = $signed({diff[64], diff[64:28]})
                     + $signed({{6{r4_d[i][31]}}, r4_d[i]});
                r5_c.dir[i] <= bps_pkg::f_sat32(acc);
            end
            r5_c.disp <= r4_disp;
            r5_c.turn <= r4_turn;

            for (int i = 0; i < 3; i++) begin
                mag = r5_c.dir[i][31] ? (~r5_c.dir[i] + 32'd1) : r5_c.dir[i];
                r6_sq[i] <= 64'(mag) * 64'(mag);
            end
            r6_c <= r5_c;

            r7_sum <= r6_sq[0] + r6_sq[1] + r6_sq[2];
            r7_c   <= r6_c;
        end
    end

    assign o_vld   = r_vld[7];
    assign o_carry = r7_c;
    assign o_sum   = r7_sum;
endmodule

// ----- design/bps_sqrt.sv -----
// integer square root, one result bit per pipeline stage (32 stages)
// depends on bps_pkg for the carried word struct
module bps_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  logic [63:0]     i_sum,
    input  bps_pkg::t_carry i_carry,
    output logic            o_vld,
    output bps_pkg::t_word  o_len,
    output bps_pkg::t_carry o_carry
);
    localparam int unsigned N = bps_pkg::SqrtSt;

    logic [63:0]     a_n   [N];
    logic [63:0]     a_res [N];
    bps_pkg::t_carry a_c   [N];
    logic [N-1:0]    r_vld;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[N-2:0], i_vld};
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_st
        localparam logic [63:0] Bit = 64'd1 << (62 - 2 * k);
        logic [63:0]     n_prev, res_prev, trial;
        bps_pkg::t_carry c_prev;
        if (k == 0) begin : g_first
            assign n_prev   = i_sum;
            assign res_prev = '0;
            assign c_prev   = i_carry;
        end else begin : g_next
            assign n_prev   = a_n[k-1];
            assign res_prev = a_res[k-1];
            assign c_prev   = a_c[k-1];
        end
        assign trial = res_prev + Bit;

        // one restoring step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_prev >= trial) begin
                    a_n[k]   <= n_prev - trial;
                    a_res[k] <= (res_prev >> 1) + Bit;
                end else begin
                    a_n[k]   <= n_prev;
                    a_res[k] <= res_prev >> 1;
                end
                a_c[k] <= c_prev;
            end
        end
    end

    assign o_vld   = r_vld[N-1];
    assign o_len   = a_res[N-1][31:0];
    assign o_carry = a_c[N-1];
endmodule

// ----- design/bps_div.sv -----
// three-lane restoring divider for renormalisation, one quotient bit per stage,
// plus setup and output stages (33 stages); depends on bps_pkg
module bps_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_vld,
    input  bps_pkg::t_word  i_len,
    input  bps_pkg::t_carry i_carry,
    output logic            o_vld,
    output bps_pkg::t_carry o_carry,
    output logic            o_degen
);
    localparam int unsigned Q = bps_pkg::QuoW;

    bps_pkg::t_div_st a_st [Q+1];
    logic [Q+1:0]     r_vld;
    bps_pkg::t_carry  r_out;
    logic             r_degen;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[Q:0], i_vld};
        end
    end

    // setup: magnitudes, numerators, overflow test (m << 28 >= len << 31)
    always_ff @(posedge i_clk) begin
        logic [31:0] mag;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                mag = i_carry.dir[i][31] ? (~i_carry.dir[i] + 32'd1) : i_carry.dir[i];
                a_st[0].lane[i].rem <= {mag, 28'd0};
                a_st[0].lane[i].q   <= '0;
                a_st[0].lane[i].ovf <= ({3'd0, mag} >= {i_len, 3'd0});
                a_st[0].lane[i].neg <= i_carry.dir[i][31];
            end
            a_st[0].len   <= i_len;
            a_st[0].degen <= (i_len == '0);
            a_st[0].disp  <= i_carry.disp;
            a_st[0].turn  <= i_carry.turn;
        end
    end

    for (genvar j = 1; j <= Q; j++) begin : g_st
        localparam int unsigned K = Q - j;
        logic [62:0] trial;
        assign trial = {31'd0, a_st[j-1].len} << K;

        // one quotient bit per lane
        always_ff @(posedge i_clk) begin
            bps_pkg::t_div_st st;
            if (i_en) begin
                st = a_st[j-1];
                for (int i = 0; i < 3; i++) begin
                    if ({3'd0, a_st[j-1].lane[i].rem} >= trial) begin
                        st.lane[i].rem  = a_st[j-1].lane[i].rem - trial[59:0];
                        st.lane[i].q[K] = 1'b1;
                    end
                end
                a_st[j] <= st;
            end
        end
    end

    // sign, clamp and degenerate handling
    always_ff @(posedge i_clk) begin
        bps_pkg::t_div_lane ln;
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                ln = a_st[Q].lane[i];
                if (a_st[Q].degen) begin
                    r_out.dir[i] <= '0;
                end else if (ln.ovf) begin
                    r_out.dir[i] <= ln.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else if (ln.neg) begin
                    r_out.dir[i] <= ~{1'b0, ln.q} + 32'd1;
                end else begin
                    r_out.dir[i] <= {1'b0, ln.q};
                end
            end
            r_out.disp <= a_st[Q].disp;
            r_out.turn <= a_st[Q].turn;
            r_degen    <= a_st[Q].degen;
        end
    end

    assign o_vld   = r_vld[Q+1];
    assign o_carry = r_out;
    assign o_degen = r_degen;
endmodule

// ----- design/brownian_particle_step_core.sv -----
// top level of the brownian particle step core: registers, front end, square root, divider
// depends on bps_pkg, bps_in_if, bps_out_if and the bps_* submodules
//
// usage:
//   i_in carries one particle word per handshake (force, torque, director, two
//   radius scalings); o_out returns one result word per particle, in order.
//   the user must write the two mobility bases through the apb-style port
//   only while idle; the block does not enforce it. words pass through 7 front-end
//   stages, 32 square-root stages (one root bit each) and 33 divider stages
//   (setup, 31 quotient bits, output clamp). throughput is one word per cycle
//   while not stalled; the whole pipeline advances together. when the
//   receiver stalls with a word waiting, the pipeline freezes and i_in.ready
//   drops; nothing is lost or repeated, and bubbles are not squeezed out.
//   synchronous active-low reset clears the valid bits and both bases.
module brownian_particle_step_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    bps_in_if.sink      i_in,
    bps_out_if.source   o_out
);
    bps_pkg::t_cfg   w_cfg;
    logic            w_en;
    logic            w_f_vld, w_s_vld, w_d_vld, w_degen;
    logic [63:0]     w_sum;
    bps_pkg::t_word  w_len;
    bps_pkg::t_carry w_f_c, w_s_c, w_d_c;

    // global advance when the last stage is empty or being taken
    assign w_en       = !w_d_vld || o_out.ready;
    assign i_in.ready = w_en;

    bps_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(w_cfg)
    );

    bps_front u_front (
        .i_clk, .i_rst_n, .i_en(w_en), .i_vld(i_in.valid),
        .i_force({i_in.force_z, i_in.force_y, i_in.force_x}),
        .i_torque({i_in.torque_z, i_in.torque_y, i_in.torque_x}),
        .i_dir({i_in.dir_in_z, i_in.dir_in_y, i_in.dir_in_x}),
        .i_trans_scale(i_in.trans_scale), .i_rot_scale(i_in.rot_scale),
        .i_cfg(w_cfg), .o_vld(w_f_vld), .o_carry(w_f_c), .o_sum(w_sum)
    );

    bps_sqrt u_sqrt (
        .i_clk, .i_rst_n, .i_en(w_en), .i_vld(w_f_vld), .i_sum(w_sum),
        .i_carry(w_f_c), .o_vld(w_s_vld), .o_len(w_len), .o_carry(w_s_c)
    );

    bps_div u_div (
        .i_clk, .i_rst_n, .i_en(w_en), .i_vld(w_s_vld), .i_len(w_len),
        .i_carry(w_s_c), .o_vld(w_d_vld), .o_carry(w_d_c), .o_degen(w_degen)
    );

    // result word
    assign o_out.valid      = w_d_vld;
    assign o_out.disp_x     = w_d_c.disp[0];
    assign o_out.disp_y     = w_d_c.disp[1];
    assign o_out.disp_z     = w_d_c.disp[2];
    assign o_out.turn_x     = w_d_c.turn[0];
    assign o_out.turn_y     = w_d_c.turn[1];
    assign o_out.turn_z     = w_d_c.turn[2];
    assign o_out.dir_out_x  = w_d_c.dir[0];
    assign o_out.dir_out_y  = w_d_c.dir[1];
    assign o_out.dir_out_z  = w_d_c.dir[2];
    assign o_out.degenerate = w_degen;

    // a degenerate word carries a zero director
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.degenerate) |->
        (o_out.dir_out_x == '0 && o_out.dir_out_y == '0 && o_out.dir_out_z == '0))
        else $error("degenerate word with nonzero director");

    // an empty output stage never blocks the input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input blocked with empty output");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    // a stalled pipeline holds the length path steady
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_en && w_s_vld) |=> $stable(w_len))
        else $error("square root moved during stall");
endmodule
